FILE: sv/rmie_pkg.sv
// ----------------------------------------------------------------------------
// rmie_pkg
// Types, codes and sizes shared by the rendezvous IPC engine and its table.
// ----------------------------------------------------------------------------
`default_nettype none

package rmie_pkg;

  localparam int NUM_PROCS = 32;
  localparam int PID_W     = $clog2(NUM_PROCS);
  localparam int CNT_W     = $clog2(NUM_PROCS + 1);
  localparam int HANDLE_W  = 32;

  localparam int IN_FW   = PID_W + 2 + PID_W + HANDLE_W;
  localparam int IN_DW   = ((IN_FW + 7) / 8) * 8;
  localparam int OUT_FW  = HANDLE_W + HANDLE_W + PID_W + 1 + PID_W;
  localparam int OUT_DW  = ((OUT_FW + 7) / 8) * 8;

  typedef enum logic [1:0] {
    OP_SEND   = 2'd0,
    OP_RECV   = 2'd1,
    OP_NOTIFY = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    MODE_IDLE      = 2'd0,
    MODE_SENDING   = 2'd1,
    MODE_RECEIVING = 2'd2
  } mode_t;

  localparam logic [1:0] KIND_SPECIFIC  = 2'd0;
  localparam logic [1:0] KIND_ANY       = 2'd1;
  localparam logic [1:0] KIND_INTERRUPT = 2'd2;
  localparam logic [1:0] KIND_RESERVED  = 2'd3;

  typedef enum logic [2:0] {
    OUT_BLOCKED     = 3'd0,
    OUT_COPIED      = 3'd1,
    OUT_INT_WRITTEN = 3'd2,
    OUT_INT_PENDING = 3'd3,
    OUT_REFUSED     = 3'd4
  } outcome_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RD_C,
    S_CHAIN,
    S_SEND_PEER,
    S_ENQ_HEAD,
    S_ENQ_WALK,
    S_RD_PEER,
    S_DQ_WALK,
    S_DQ_FIX,
    S_DQ_FREE,
    S_DONE
  } state_t;

  // One process entry of the rendezvous table.
  typedef struct packed {
    mode_t                mode;
    logic [PID_W-1:0]     send_target;
    logic [1:0]           wait_kind;
    logic [PID_W-1:0]     wait_pid;
    logic [HANDLE_W-1:0]  held_handle;
    logic                 int_pending;
    logic [PID_W-1:0]     queue_head;
    logic                 head_valid;
    logic [PID_W-1:0]     queue_next;
    logic                 next_valid;
  } rec_t;

  typedef struct packed {
    logic                 rd_en;
    logic [PID_W-1:0]     rd_addr;
    logic                 wr_en;
    logic [PID_W-1:0]     wr_addr;
    rec_t                 wr_data;
  } tbl_req_t;

  typedef struct packed {
    outcome_t             outcome;
    logic [HANDLE_W-1:0]  copy_from;
    logic [HANDLE_W-1:0]  copy_to;
    logic [PID_W-1:0]     source;
    logic                 woken_valid;
    logic [PID_W-1:0]     woken_pid;
  } res_t;

endpackage

`default_nettype wire

FILE: sv/rendezvous_message_ipc_engine_unit.sv
// A notify or a refused request passes S_RD_C and S_DONE on its way to the output
// register; a send or receive may also walk the send chain or a sender queue,
// with one table read per walk step.
// One request is worked on at a time; the next is taken once the result sits in the
// output register. Reset (synchronous, active low) marks every entry idle with no
// pending interrupt and an empty queue at once; no clearing pass.
// ----------------------------------------------------------------------------
// rendezvous_message_ipc_engine_unit
// Synchronous rendezvous message engine over a per-process table in memory.
// ----------------------------------------------------------------------------
`default_nettype none

module rendezvous_message_ipc_engine_unit (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_tvalid,
  output logic                              in_tready,
  // process_id, peer_kind, peer_pid, message_handle (lowest bit up)
  input  wire logic [rmie_pkg::IN_DW-1:0]   in_tdata,
  // operation
  input  wire logic [1:0]                   in_tuser,
  output logic                              out_tvalid,
  input  wire logic                         out_tready,
  // copy_from_handle, copy_to_handle, message_source, woken_valid, woken_pid
  output logic [rmie_pkg::OUT_DW-1:0]       out_tdata,
  // outcome
  output logic [2:0]                        out_tuser
);

  localparam int PW = rmie_pkg::PID_W;
  localparam int HW = rmie_pkg::HANDLE_W;
  localparam int CW = rmie_pkg::CNT_W;

  rmie_pkg::state_t st_r, st_nxt;
  logic [1:0]       op_r, op_nxt;
  logic [PW-1:0]    c_r, c_nxt;
  logic [1:0]       kind_r, kind_nxt;
  logic [PW-1:0]    peer_r, peer_nxt;
  logic [HW-1:0]    m_r, m_nxt;
  rmie_pkg::rec_t   cr_r, cr_nxt;
  rmie_pkg::rec_t   pr_r, pr_nxt;
  rmie_pkg::rec_t   qr_r, qr_nxt;
  logic [PW-1:0]    p_r, p_nxt;
  logic [PW-1:0]    prev_r, prev_nxt;
  logic [PW-1:0]    from_r, from_nxt;
  logic             havep_r, havep_nxt;
  logic [CW-1:0]    n_r, n_nxt;
  rmie_pkg::res_t   res_r, res_nxt;
  logic             out_valid_r, out_valid_nxt;
  rmie_pkg::res_t   out_res_r, out_res_nxt;

  rmie_pkg::tbl_req_t req;
  rmie_pkg::rec_t     r;

  logic in_fire, out_free;
  logic notify_hit, send_bad, recv_bad, recv_int, recv_any, recv_spec;
  logic chain_end, chain_fail, peer_rdy, walk_more, spec_match, dq_hit, dq_stop;

  rmie_table u_table (
    .clk    (clk),
    .rst_n  (rst_n),
    .req    (req),
    .rd_rec (r)
  );

  function automatic rmie_pkg::res_t refused();
    rmie_pkg::res_t x;
    x = '0;
    x.outcome = rmie_pkg::OUT_REFUSED;
    return x;
  endfunction

  function automatic rmie_pkg::rec_t block_recv(rmie_pkg::rec_t base, logic [HW-1:0] m,
                                                 logic [1:0] kind, logic [PW-1:0] peer);
    rmie_pkg::rec_t x;
    x = base;
    x.mode        = rmie_pkg::MODE_RECEIVING;
    x.held_handle = m;
    x.wait_kind   = kind;
    x.wait_pid    = (kind == rmie_pkg::KIND_SPECIFIC) ? peer : '0;
    return x;
  endfunction

  assign in_fire   = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;
  assign in_tready = (st_r == rmie_pkg::S_IDLE);

  assign notify_hit = (r.mode == rmie_pkg::MODE_RECEIVING) &&
                      (r.wait_kind == rmie_pkg::KIND_INTERRUPT ||
                       r.wait_kind == rmie_pkg::KIND_ANY);
  assign send_bad   = (r.mode != rmie_pkg::MODE_IDLE) || (peer_r == c_r);
  assign recv_bad   = (r.mode != rmie_pkg::MODE_IDLE) ||
                      (kind_r == rmie_pkg::KIND_RESERVED) ||
                      (kind_r == rmie_pkg::KIND_SPECIFIC && peer_r == c_r);
  assign recv_int   = r.int_pending && (kind_r != rmie_pkg::KIND_SPECIFIC);
  assign recv_any   = (kind_r == rmie_pkg::KIND_ANY) && r.head_valid;
  assign recv_spec  = (kind_r == rmie_pkg::KIND_SPECIFIC);
  assign chain_end  = (r.mode != rmie_pkg::MODE_SENDING);
  assign chain_fail = (r.send_target == c_r) ||
                      (n_r == CW'(rmie_pkg::NUM_PROCS - 1));
  assign peer_rdy   = (r.mode == rmie_pkg::MODE_RECEIVING) &&
                      ((r.wait_kind == rmie_pkg::KIND_SPECIFIC && r.wait_pid == c_r) ||
                       r.wait_kind == rmie_pkg::KIND_ANY);
  assign walk_more  = (n_r < CW'(rmie_pkg::NUM_PROCS)) && r.next_valid;
  assign spec_match = (r.mode == rmie_pkg::MODE_SENDING) && (r.send_target == c_r) &&
                      cr_r.head_valid;
  assign dq_hit     = (p_r == from_r);
  assign dq_stop    = !r.next_valid || (n_r + 1'b1 == CW'(rmie_pkg::NUM_PROCS));

  // Next state.
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      rmie_pkg::S_IDLE: begin
        if (in_fire) st_nxt = rmie_pkg::S_RD_C;
      end
      rmie_pkg::S_RD_C: begin
        st_nxt = rmie_pkg::S_DONE;
        if (op_r == rmie_pkg::OP_SEND && !send_bad) begin
          st_nxt = rmie_pkg::S_CHAIN;
        end else if (op_r == rmie_pkg::OP_RECV && !recv_bad && !recv_int) begin
          if (recv_any)       st_nxt = rmie_pkg::S_DQ_WALK;
          else if (recv_spec) st_nxt = rmie_pkg::S_RD_PEER;
        end
      end
      rmie_pkg::S_CHAIN: begin
        if (chain_end)       st_nxt = rmie_pkg::S_SEND_PEER;
        else if (chain_fail) st_nxt = rmie_pkg::S_DONE;
      end
      rmie_pkg::S_SEND_PEER: begin
        if (peer_rdy)          st_nxt = rmie_pkg::S_DONE;
        else if (!r.head_valid) st_nxt = rmie_pkg::S_ENQ_HEAD;
        else                   st_nxt = rmie_pkg::S_ENQ_WALK;
      end
      rmie_pkg::S_ENQ_HEAD: st_nxt = rmie_pkg::S_DONE;
      rmie_pkg::S_ENQ_WALK: begin
        if (!walk_more) st_nxt = rmie_pkg::S_DONE;
      end
      rmie_pkg::S_RD_PEER: begin
        st_nxt = spec_match ? rmie_pkg::S_DQ_WALK : rmie_pkg::S_DONE;
      end
      rmie_pkg::S_DQ_WALK: begin
        if (dq_hit)       st_nxt = rmie_pkg::S_DQ_FIX;
        else if (dq_stop) st_nxt = rmie_pkg::S_DONE;
      end
      rmie_pkg::S_DQ_FIX:  st_nxt = rmie_pkg::S_DQ_FREE;
      rmie_pkg::S_DQ_FREE: st_nxt = rmie_pkg::S_DONE;
      rmie_pkg::S_DONE: begin
        if (out_free) st_nxt = rmie_pkg::S_IDLE;
      end
      default: st_nxt = rmie_pkg::S_IDLE;
    endcase
  end

  // Datapath, table accesses and result.
  always_comb begin
    op_nxt        = op_r;
    c_nxt         = c_r;
    kind_nxt      = kind_r;
    peer_nxt      = peer_r;
    m_nxt         = m_r;
    cr_nxt        = cr_r;
    pr_nxt        = pr_r;
    qr_nxt        = qr_r;
    p_nxt         = p_r;
    prev_nxt      = prev_r;
    from_nxt      = from_r;
    havep_nxt     = havep_r;
    n_nxt         = n_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_res_nxt   = out_res_r;
    req           = '0;

    case (st_r)
      rmie_pkg::S_IDLE: begin
        if (in_fire) begin
          op_nxt      = in_tuser;
          c_nxt       = in_tdata[PW-1:0];
          kind_nxt    = in_tdata[PW+1:PW];
          peer_nxt    = in_tdata[2*PW+1:PW+2];
          m_nxt       = in_tdata[2*PW+2+HW-1:2*PW+2];
          req.rd_en   = 1'b1;
          req.rd_addr = in_tdata[PW-1:0];
        end
      end

      rmie_pkg::S_RD_C: begin
        cr_nxt  = r;
        res_nxt = refused();
        case (op_r)
          rmie_pkg::OP_NOTIFY: begin
            req.wr_en   = 1'b1;
            req.wr_addr = c_r;
            req.wr_data = r;
            res_nxt     = '0;
            if (notify_hit) begin
              req.wr_data.held_handle = '0;
              req.wr_data.int_pending = 1'b0;
              req.wr_data.mode        = rmie_pkg::MODE_IDLE;
              res_nxt.outcome         = rmie_pkg::OUT_INT_WRITTEN;
              res_nxt.copy_to         = r.held_handle;
              res_nxt.woken_valid     = 1'b1;
              res_nxt.woken_pid       = c_r;
            end else begin
              req.wr_data.int_pending = 1'b1;
              res_nxt.outcome         = rmie_pkg::OUT_INT_PENDING;
            end
          end
          rmie_pkg::OP_SEND: begin
            if (!send_bad) begin
              req.rd_en   = 1'b1;
              req.rd_addr = peer_r;
              p_nxt       = peer_r;
              n_nxt       = '0;
            end
          end
          rmie_pkg::OP_RECV: begin
            if (!recv_bad) begin
              res_nxt = '0;
              if (recv_int) begin
                req.wr_en               = 1'b1;
                req.wr_addr             = c_r;
                req.wr_data             = r;
                req.wr_data.int_pending = 1'b0;
                res_nxt.outcome         = rmie_pkg::OUT_INT_WRITTEN;
                res_nxt.copy_to         = m_r;
              end else if (recv_any) begin
                p_nxt       = r.queue_head;
                from_nxt    = r.queue_head;
                havep_nxt   = 1'b0;
                n_nxt       = '0;
                req.rd_en   = 1'b1;
                req.rd_addr = r.queue_head;
              end else if (recv_spec) begin
                req.rd_en   = 1'b1;
                req.rd_addr = peer_r;
              end else begin
                req.wr_en   = 1'b1;
                req.wr_addr = c_r;
                req.wr_data = block_recv(r, m_r, kind_r, peer_r);
                res_nxt.outcome = rmie_pkg::OUT_BLOCKED;
              end
            end
          end
          default: res_nxt = refused();
        endcase
      end

      rmie_pkg::S_CHAIN: begin
        if (chain_end) begin
          req.rd_en   = 1'b1;
          req.rd_addr = peer_r;
        end else if (chain_fail) begin
          res_nxt = refused();
        end else begin
          n_nxt       = n_r + 1'b1;
          p_nxt       = r.send_target;
          req.rd_en   = 1'b1;
          req.rd_addr = r.send_target;
        end
      end

      rmie_pkg::S_SEND_PEER: begin
        pr_nxt  = r;
        res_nxt = '0;
        req.wr_en = 1'b1;
        if (peer_rdy) begin
          req.wr_addr             = peer_r;
          req.wr_data             = r;
          req.wr_data.held_handle = '0;
          req.wr_data.mode        = rmie_pkg::MODE_IDLE;
          res_nxt.outcome         = rmie_pkg::OUT_COPIED;
          res_nxt.copy_from       = m_r;
          res_nxt.copy_to         = r.held_handle;
          res_nxt.source          = c_r;
          res_nxt.woken_valid     = 1'b1;
          res_nxt.woken_pid       = peer_r;
        end else begin
          req.wr_addr             = c_r;
          req.wr_data             = cr_r;
          req.wr_data.mode        = rmie_pkg::MODE_SENDING;
          req.wr_data.send_target = peer_r;
          req.wr_data.held_handle = m_r;
          req.wr_data.next_valid  = 1'b0;
          res_nxt.outcome         = rmie_pkg::OUT_BLOCKED;
          if (r.head_valid) begin
            // The caller was idle, so it sits in no queue and the walk never
            // reads the entry being written now.
            p_nxt       = r.queue_head;
            n_nxt       = '0;
            req.rd_en   = 1'b1;
            req.rd_addr = r.queue_head;
          end
        end
      end

      rmie_pkg::S_ENQ_HEAD: begin
        req.wr_en              = 1'b1;
        req.wr_addr            = peer_r;
        req.wr_data            = pr_r;
        req.wr_data.head_valid = 1'b1;
        req.wr_data.queue_head = c_r;
      end

      rmie_pkg::S_ENQ_WALK: begin
        if (walk_more) begin
          n_nxt       = n_r + 1'b1;
          p_nxt       = r.queue_next;
          req.rd_en   = 1'b1;
          req.rd_addr = r.queue_next;
        end else begin
          req.wr_en              = 1'b1;
          req.wr_addr            = p_r;
          req.wr_data            = r;
          req.wr_data.next_valid = 1'b1;
          req.wr_data.queue_next = c_r;
        end
      end

      rmie_pkg::S_RD_PEER: begin
        if (spec_match) begin
          from_nxt    = peer_r;
          p_nxt       = cr_r.queue_head;
          havep_nxt   = 1'b0;
          n_nxt       = '0;
          req.rd_en   = 1'b1;
          req.rd_addr = cr_r.queue_head;
        end else begin
          req.wr_en       = 1'b1;
          req.wr_addr     = c_r;
          req.wr_data     = block_recv(cr_r, m_r, kind_r, peer_r);
          res_nxt         = '0;
          res_nxt.outcome = rmie_pkg::OUT_BLOCKED;
        end
      end

      rmie_pkg::S_DQ_WALK: begin
        if (dq_hit) begin
          qr_nxt              = r;
          res_nxt             = '0;
          res_nxt.outcome     = rmie_pkg::OUT_COPIED;
          res_nxt.copy_from   = r.held_handle;
          res_nxt.copy_to     = m_r;
          res_nxt.source      = from_r;
          res_nxt.woken_valid = 1'b1;
          res_nxt.woken_pid   = from_r;
        end else begin
          prev_nxt  = p_r;
          pr_nxt    = r;
          havep_nxt = 1'b1;
          n_nxt     = n_r + 1'b1;
          if (dq_stop) begin
            req.wr_en       = 1'b1;
            req.wr_addr     = c_r;
            req.wr_data     = block_recv(cr_r, m_r, kind_r, peer_r);
            res_nxt         = '0;
            res_nxt.outcome = rmie_pkg::OUT_BLOCKED;
          end else begin
            p_nxt       = r.queue_next;
            req.rd_en   = 1'b1;
            req.rd_addr = r.queue_next;
          end
        end
      end

      rmie_pkg::S_DQ_FIX: begin
        req.wr_en = 1'b1;
        if (havep_r) begin
          req.wr_addr            = prev_r;
          req.wr_data            = pr_r;
          req.wr_data.next_valid = qr_r.next_valid;
          req.wr_data.queue_next = qr_r.queue_next;
        end else begin
          req.wr_addr            = c_r;
          req.wr_data            = cr_r;
          req.wr_data.head_valid = qr_r.next_valid;
          req.wr_data.queue_head = qr_r.queue_next;
        end
      end

      rmie_pkg::S_DQ_FREE: begin
        req.wr_en               = 1'b1;
        req.wr_addr             = p_r;
        req.wr_data             = qr_r;
        req.wr_data.next_valid  = 1'b0;
        req.wr_data.held_handle = '0;
        req.wr_data.mode        = rmie_pkg::MODE_IDLE;
      end

      rmie_pkg::S_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_res_nxt   = res_r;
        end
      end

      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= rmie_pkg::S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r      <= op_nxt;
    c_r       <= c_nxt;
    kind_r    <= kind_nxt;
    peer_r    <= peer_nxt;
    m_r       <= m_nxt;
    cr_r      <= cr_nxt;
    pr_r      <= pr_nxt;
    qr_r      <= qr_nxt;
    p_r       <= p_nxt;
    prev_r    <= prev_nxt;
    from_r    <= from_nxt;
    havep_r   <= havep_nxt;
    n_r       <= n_nxt;
    res_r     <= res_nxt;
    out_res_r <= out_res_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_res_r.outcome;
  assign out_tdata  = {{(rmie_pkg::OUT_DW - rmie_pkg::OUT_FW){1'b0}},
                       out_res_r.woken_pid, out_res_r.woken_valid, out_res_r.source,
                       out_res_r.copy_to, out_res_r.copy_from};

  // A read must never meet a write to the same entry, as no forwarding exists.
  a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
    req.wr_en && req.rd_en |-> req.wr_addr != req.rd_addr)
    else $error("table read and write hit the same entry");

  a_done_loads: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == rmie_pkg::S_DONE && out_free |=> out_valid_r && st_r == rmie_pkg::S_IDLE)
    else $error("finished result not loaded into the output register");

  a_woken_outcome: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_res_r.woken_valid |->
      out_res_r.outcome == rmie_pkg::OUT_COPIED ||
      out_res_r.outcome == rmie_pkg::OUT_INT_WRITTEN)
    else $error("process woken on an outcome that releases nobody");

endmodule

`default_nettype wire

FILE: sv/rmie_table.sv
// ----------------------------------------------------------------------------
// rmie_table
// Process table memory with registered read and a written flag per
// entry; an entry never written reads as the all-zero reset record.
// ----------------------------------------------------------------------------
`default_nettype none

module rmie_table (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire rmie_pkg::tbl_req_t req,
  output rmie_pkg::rec_t         rd_rec
);

  rmie_pkg::rec_t mem [rmie_pkg::NUM_PROCS];
  logic [rmie_pkg::NUM_PROCS-1:0] written_r;
  rmie_pkg::rec_t rd_q_r;
  logic           rd_v_r;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_q_r <= mem[req.rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      written_r <= '0;
      rd_v_r    <= 1'b0;
    end else begin
      if (req.wr_en) begin
        written_r[req.wr_addr] <= 1'b1;
      end
      if (req.rd_en) begin
        rd_v_r <= written_r[req.rd_addr];
      end
    end
  end

  assign rd_rec = rd_v_r ? rd_q_r : '0;

endmodule

`default_nettype wire

FILE: test/testbench.sv
// ----------------------------------------------------------------------------
// Rendezvous IPC engine testbench
// Drives send, receive and notify requests, keeps its own copy of the process
// table and checks every outcome field by field, under varied flow control.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int NP = rmie_pkg::NUM_PROCS;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam logic [1:0] OP_INVALID = 2'd3;

  typedef struct packed {
    logic [2:0]  outcome;
    logic [31:0] from_h;
    logic [31:0] to_h;
    logic [4:0]  source;
    logic        woken_v;
    logic [4:0]  woken_p;
  } reply_t;

  typedef struct {
    logic [1:0]  op;
    logic [4:0]  pid;
    logic [1:0]  kind;
    logic [4:0]  peer;
    logic [31:0] handle;
    bit          fixed;
    logic [2:0]  outcome;
  } req_row_t;

  logic clk, rst_n;
  logic in_tvalid, in_tready, out_tvalid, out_tready;
  logic [rmie_pkg::IN_DW-1:0] in_tdata;
  logic [1:0] in_tuser;
  logic [rmie_pkg::OUT_DW-1:0] out_tdata;
  logic [2:0] out_tuser;

  rendezvous_message_ipc_engine_unit dut (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata, .in_tuser,
    .out_tvalid, .out_tready, .out_tdata, .out_tuser
  );

  // Shadow process table.
  rmie_pkg::mode_t t_mode [NP];
  logic [4:0]  t_target [NP];
  logic [1:0]  t_wkind [NP];
  logic [4:0]  t_wpid [NP];
  logic [31:0] t_held [NP];
  bit          t_intp [NP];
  logic [4:0]  t_head [NP];
  bit          t_headv [NP];
  logic [4:0]  t_next [NP];
  bit          t_nextv [NP];

  reply_t pending_replies[$];
  int mismatches = 0, accepted = 0, replies = 0, idle_cycles = 0;
  int send_idle = 0, recv_idle = 0;
  int n_outcome [5];
  bit finished = 0;

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  function automatic bit chain_closes(logic [4:0] caller, logic [4:0] dest);
    logic [4:0] p = dest;
    for (int n = 0; n < NP; n++) begin
      if (t_mode[p] != rmie_pkg::MODE_SENDING) return 0;
      if (t_target[p] == caller) return 1;
      p = t_target[p];
    end
    return 1;
  endfunction

  function automatic void queue_sender(logic [4:0] dest, logic [4:0] who);
    logic [4:0] p;
    t_nextv[who] = 0;
    if (!t_headv[dest]) begin
      t_headv[dest] = 1;
      t_head[dest] = who;
      return;
    end
    p = t_head[dest];
    for (int n = 0; n < NP && t_nextv[p]; n++) p = t_next[p];
    t_nextv[p] = 1;
    t_next[p] = who;
  endfunction

  function automatic bit unlink_sender(logic [4:0] dest, logic [4:0] who);
    logic [4:0] p = t_head[dest], prev = 0;
    bit have_prev = 0, cur = t_headv[dest];
    for (int n = 0; n < NP && cur; n++) begin
      if (p == who) begin
        if (have_prev) begin
          t_nextv[prev] = t_nextv[p];
          t_next[prev] = t_next[p];
        end else begin
          t_headv[dest] = t_nextv[p];
          t_head[dest] = t_next[p];
        end
        t_nextv[p] = 0;
        return 1;
      end
      prev = p;
      have_prev = 1;
      cur = t_nextv[p];
      p = t_next[p];
    end
    return 0;
  endfunction

  function automatic reply_t mk(logic [2:0] oc, logic [31:0] f = 0, logic [31:0] t = 0,
                                logic [4:0] s = 0, logic wv = 0, logic [4:0] wp = 0);
    reply_t r;
    r.outcome = oc; r.from_h = f; r.to_h = t; r.source = s; r.woken_v = wv; r.woken_p = wp;
    return r;
  endfunction

  function automatic reply_t rendezvous_outcome(logic [1:0] op, logic [4:0] c,
                                                logic [1:0] kind, logic [4:0] peer,
                                                logic [31:0] m);
    logic [31:0] h;
    logic [4:0] from;
    bit found;
    if (op == OP_INVALID) return mk(rmie_pkg::OUT_REFUSED);
    if (op == rmie_pkg::OP_NOTIFY) begin
      if (t_mode[c] == rmie_pkg::MODE_RECEIVING &&
          (t_wkind[c] == rmie_pkg::KIND_INTERRUPT || t_wkind[c] == rmie_pkg::KIND_ANY)) begin
        h = t_held[c];
        t_held[c] = 0;
        t_intp[c] = 0;
        t_mode[c] = rmie_pkg::MODE_IDLE;
        return mk(rmie_pkg::OUT_INT_WRITTEN, 0, h, 0, 1, c);
      end
      t_intp[c] = 1;
      return mk(rmie_pkg::OUT_INT_PENDING);
    end
    if (t_mode[c] != rmie_pkg::MODE_IDLE) return mk(rmie_pkg::OUT_REFUSED);
    if (op == rmie_pkg::OP_SEND) begin
      if (peer == c || chain_closes(c, peer)) return mk(rmie_pkg::OUT_REFUSED);
      if (t_mode[peer] == rmie_pkg::MODE_RECEIVING &&
          ((t_wkind[peer] == rmie_pkg::KIND_SPECIFIC && t_wpid[peer] == c) ||
           t_wkind[peer] == rmie_pkg::KIND_ANY)) begin
        h = t_held[peer];
        t_held[peer] = 0;
        t_mode[peer] = rmie_pkg::MODE_IDLE;
        return mk(rmie_pkg::OUT_COPIED, m, h, c, 1, peer);
      end
      t_mode[c] = rmie_pkg::MODE_SENDING;
      t_target[c] = peer;
      t_held[c] = m;
      queue_sender(peer, c);
      return mk(rmie_pkg::OUT_BLOCKED);
    end
    if (kind == rmie_pkg::KIND_RESERVED || (kind == rmie_pkg::KIND_SPECIFIC && peer == c))
      return mk(rmie_pkg::OUT_REFUSED);
    if (t_intp[c] && (kind == rmie_pkg::KIND_ANY || kind == rmie_pkg::KIND_INTERRUPT)) begin
      t_intp[c] = 0;
      return mk(rmie_pkg::OUT_INT_WRITTEN, 0, m);
    end
    found = 0;
    from = 0;
    if (kind == rmie_pkg::KIND_ANY && t_headv[c]) begin
      from = t_head[c];
      found = unlink_sender(c, from);
    end else if (kind == rmie_pkg::KIND_SPECIFIC && t_mode[peer] == rmie_pkg::MODE_SENDING &&
                 t_target[peer] == c) begin
      from = peer;
      found = unlink_sender(c, from);
    end
    if (found) begin
      h = t_held[from];
      t_held[from] = 0;
      t_mode[from] = rmie_pkg::MODE_IDLE;
      return mk(rmie_pkg::OUT_COPIED, h, m, from, 1, from);
    end
    t_mode[c] = rmie_pkg::MODE_RECEIVING;
    t_held[c] = m;
    t_wkind[c] = kind;
    t_wpid[c] = (kind == rmie_pkg::KIND_SPECIFIC) ? peer : 5'd0;
    return mk(rmie_pkg::OUT_BLOCKED);
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    mismatches++;
    $display("MISMATCH transfer %0d: %s got 0x%0h, expected 0x%0h", replies, what, got, want);
  endtask

  // Drives one request and waits for its transfer; the valid stays up only
  // until the next falling edge, where the next request or an idle gap follows.
  task automatic issue(logic [1:0] op, logic [4:0] pid, logic [1:0] kind, logic [4:0] peer,
                       logic [31:0] handle, bit fixed = 0, logic [2:0] oc = 0);
    reply_t r;
    while (send_idle > 0 && $urandom_range(99) < send_idle) begin
      in_tvalid <= 0;
      @(negedge clk);
    end
    r = rendezvous_outcome(op, pid, kind, peer, handle);
    if (fixed && r.outcome != oc) report_mismatch("tabled outcome", 32'(r.outcome), 32'(oc));
    pending_replies.push_back(r);
    in_tuser <= op;
    in_tdata <= {{(rmie_pkg::IN_DW - rmie_pkg::IN_FW){1'b0}}, handle, peer, kind, pid};
    in_tvalid <= 1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    accepted++;
    @(negedge clk);
  endtask

  task automatic drain();
    in_tvalid <= 0;
    @(negedge clk);
    while (pending_replies.size() > 0) @(negedge clk);
  endtask

  always @(negedge clk)
    out_tready <= !(recv_idle > 0 && $urandom_range(99) < recv_idle);

  always @(posedge clk) begin
    reply_t want, got;
    if (rst_n && out_tvalid && out_tready) begin
      got.outcome = out_tuser;
      {got.woken_p, got.woken_v, got.source, got.to_h, got.from_h} =
        out_tdata[rmie_pkg::OUT_FW-1:0];
      replies++;
      if (pending_replies.size() == 0) begin
        report_mismatch("unexpected transfer, outcome", 32'(out_tuser), 32'(0));
      end else begin
        want = pending_replies.pop_front();
        n_outcome[want.outcome]++;
        if (got.outcome != want.outcome)
          report_mismatch("outcome", 32'(got.outcome), 32'(want.outcome));
        if (got.from_h != want.from_h) report_mismatch("copy_from", got.from_h, want.from_h);
        if (got.to_h != want.to_h) report_mismatch("copy_to", got.to_h, want.to_h);
        if (got.source != want.source)
          report_mismatch("source", 32'(got.source), 32'(want.source));
        if (got.woken_v != want.woken_v)
          report_mismatch("woken_valid", 32'(got.woken_v), 32'(want.woken_v));
        if (got.woken_p != want.woken_p)
          report_mismatch("woken_pid", 32'(got.woken_p), 32'(want.woken_p));
      end
    end
  end

  // Watchdog: cycles without any transfer on either side.
  always @(posedge clk) begin
    if (finished || !rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready))
      idle_cycles <= 0;
    else if (pending_replies.size() > 0 || in_tvalid)
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog expired");
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Mostly well-formed: receivers and senders pairing up, some interrupts, some noise.
  task automatic random_item();
    int r = $urandom_range(99);
    logic [4:0] c = 5'($urandom_range(NP - 1)), p = 5'($urandom_range(NP - 1));
    logic [31:0] h = $urandom;
    if (r < 5) begin
      issue(OP_INVALID, c, 2'($urandom_range(3)), p, h);
    end else if (r < 40) begin
      // prefer idle callers so that the table fills up
      for (int k = 0; k < 4 && t_mode[c] != rmie_pkg::MODE_IDLE; k++)
        c = 5'($urandom_range(NP - 1));
      if (p == c && $urandom_range(9) != 0) p = c + 5'd1;
      issue(rmie_pkg::OP_SEND, c, 2'($urandom_range(3)), p, h);
    end else if (r < 85) begin
      for (int k = 0; k < 4 && t_mode[c] != rmie_pkg::MODE_IDLE; k++)
        c = 5'($urandom_range(NP - 1));
      if (t_headv[c] && $urandom_range(1)) p = t_head[c];
      if (p == c && $urandom_range(9) != 0) p = c + 5'd1;
      issue(rmie_pkg::OP_RECV, c,
            ($urandom_range(19) == 0) ? rmie_pkg::KIND_RESERVED : 2'($urandom_range(2)),
            p, h);
    end else begin
      issue(rmie_pkg::OP_NOTIFY, c, 2'($urandom_range(3)), p, h);
    end
  endtask

  req_row_t dir_rows [22];

  initial begin
    rst_n = 0;
    in_tvalid = 0;
    in_tdata = '0;
    in_tuser = rmie_pkg::OP_SEND;
    out_tready = 0;
    for (int i = 0; i < NP; i++) begin
      t_mode[i] = rmie_pkg::MODE_IDLE; t_intp[i] = 0; t_headv[i] = 0; t_nextv[i] = 0;
      t_target[i] = 0; t_wkind[i] = 0; t_wpid[i] = 0; t_held[i] = 0;
      t_head[i] = 0; t_next[i] = 0;
    end
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    // op, pid, kind, peer, handle, outcome typed in, outcome
    dir_rows = '{
      '{OP_INVALID, 5'd0, rmie_pkg::KIND_SPECIFIC, 5'd1, 32'h0, 1, rmie_pkg::OUT_REFUSED},
      '{rmie_pkg::OP_SEND, 5'd3, rmie_pkg::KIND_SPECIFIC, 5'd3, 32'hFFFF_FFFF, 1,
        rmie_pkg::OUT_REFUSED},
      '{rmie_pkg::OP_RECV, 5'd4, rmie_pkg::KIND_RESERVED, 5'd1, 32'h1, 1,
        rmie_pkg::OUT_REFUSED},
      '{rmie_pkg::OP_RECV, 5'd4, rmie_pkg::KIND_SPECIFIC, 5'd4, 32'h1, 1,
        rmie_pkg::OUT_REFUSED},
      '{rmie_pkg::OP_NOTIFY, 5'd31, rmie_pkg::KIND_RESERVED, 5'd31, 32'hFFFF_FFFF, 1,
        rmie_pkg::OUT_INT_PENDING},
      '{rmie_pkg::OP_RECV, 5'd31, rmie_pkg::KIND_INTERRUPT, 5'd0, 32'hA5A5_5A5A, 0, 0},
      '{rmie_pkg::OP_RECV, 5'd0, rmie_pkg::KIND_INTERRUPT, 5'd0, 32'h0000_1000, 1,
        rmie_pkg::OUT_BLOCKED},
      '{rmie_pkg::OP_NOTIFY, 5'd0, rmie_pkg::KIND_SPECIFIC, 5'd0, 32'h0, 0, 0},
      '{rmie_pkg::OP_SEND, 5'd1, rmie_pkg::KIND_SPECIFIC, 5'd2, 32'h1111_0000, 1,
        rmie_pkg::OUT_BLOCKED},
      '{rmie_pkg::OP_SEND, 5'd1, rmie_pkg::KIND_SPECIFIC, 5'd5, 32'h0, 1,
        rmie_pkg::OUT_REFUSED},
      '{rmie_pkg::OP_SEND, 5'd2, rmie_pkg::KIND_SPECIFIC, 5'd1, 32'h2, 1,
        rmie_pkg::OUT_REFUSED},
      '{rmie_pkg::OP_SEND, 5'd6, rmie_pkg::KIND_SPECIFIC, 5'd2, 32'h6666_6666, 0, 0},
      '{rmie_pkg::OP_SEND, 5'd7, rmie_pkg::KIND_SPECIFIC, 5'd2, 32'h7777_7777, 0, 0},
      '{rmie_pkg::OP_RECV, 5'd2, rmie_pkg::KIND_SPECIFIC, 5'd6, 32'h2222_0000, 0, 0},
      '{rmie_pkg::OP_RECV, 5'd2, rmie_pkg::KIND_ANY, 5'd0, 32'hFFFF_FFFF, 0, 0},
      '{rmie_pkg::OP_RECV, 5'd2, rmie_pkg::KIND_ANY, 5'd31, 32'h0, 0, 0},
      '{rmie_pkg::OP_RECV, 5'd2, rmie_pkg::KIND_ANY, 5'd0, 32'h2, 1, rmie_pkg::OUT_BLOCKED},
      '{rmie_pkg::OP_SEND, 5'd31, rmie_pkg::KIND_RESERVED, 5'd2, 32'h8000_0001, 0, 0},
      '{rmie_pkg::OP_RECV, 5'd9, rmie_pkg::KIND_SPECIFIC, 5'd31, 32'h9, 1,
        rmie_pkg::OUT_BLOCKED},
      '{rmie_pkg::OP_SEND, 5'd31, rmie_pkg::KIND_SPECIFIC, 5'd9, 32'hDEAD_BEEF, 0, 0},
      '{rmie_pkg::OP_RECV, 5'd10, rmie_pkg::KIND_ANY, 5'd0, 32'h10, 0, 0},
      '{rmie_pkg::OP_NOTIFY, 5'd10, rmie_pkg::KIND_SPECIFIC, 5'd0, 32'h0, 0, 0}
    };
    foreach (dir_rows[i])
      issue(dir_rows[i].op, dir_rows[i].pid, dir_rows[i].kind, dir_rows[i].peer,
            dir_rows[i].handle, dir_rows[i].fixed, dir_rows[i].outcome);

    for (int phase = 0; phase < 3; phase++) begin
      send_idle = (phase == 0) ? 37 : (phase == 1) ? 68 : 0;
      recv_idle = (phase == 0) ? 68 : (phase == 1) ? 37 : 0;
      for (int i = 0; i < 480; i++) begin
        if (i == 240) drain();
        random_item();
      end
    end

    send_idle = 0;
    recv_idle = 0;
    drain();
    repeat (2 * NP + 16) @(posedge clk);
    finished = 1;
    $display("%0d requests, %0d results: blocked %0d, copied %0d, int written %0d,",
             accepted, replies, n_outcome[rmie_pkg::OUT_BLOCKED],
             n_outcome[rmie_pkg::OUT_COPIED], n_outcome[rmie_pkg::OUT_INT_WRITTEN]);
    $display("int pending %0d, refused %0d, over three flow-control phases",
             n_outcome[rmie_pkg::OUT_INT_PENDING], n_outcome[rmie_pkg::OUT_REFUSED]);
    if (mismatches == 0 && pending_replies.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

`default_nettype wire
